### hw/rtl/ntps_pkg.sv
// package for the nearest-three periodic select block
// shared types, sizes, register codes and slot sentinels; no dependencies
`timescale 1ns / 1ps

package ntps_pkg;

  localparam int unsigned MAX_ATOMS  = 512;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned BOX_W      = 24;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIST_W     = 64;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [BOX_W-1:0] BOX_RESET = 24'd1036268;

  // distance pipeline and queue sizing
  localparam int unsigned PIPE_DEPTH = 6;
  localparam int unsigned INFL_W     = $clog2(PIPE_DEPTH + 1);
  localparam int unsigned QDEPTH     = 8;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  // 16, 17 and 18 angstrom squared, Q32.32
  localparam logic [DIST_W-1:0] SENT0 = {32'd256, 32'd0};
  localparam logic [DIST_W-1:0] SENT1 = {32'd289, 32'd0};
  localparam logic [DIST_W-1:0] SENT2 = {32'd324, 32'd0};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_EDGE = 2'd0,
    REG_CENTER_X = 2'd1,
    REG_CENTER_Y = 2'd2,
    REG_CENTER_Z = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BOX_W-1:0]          box_edge;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
  } cfg_t;

  typedef struct packed {
    logic             consider;
    logic [IDX_W-1:0] idx;
    logic             last;
  } meta_t;

  typedef struct packed {
    meta_t             meta;
    logic [DIST_W-1:0] dsq;
  } dist_item_t;

endpackage

### hw/rtl/ntps_intf.sv
// request channel interfaces for atoms in and selection results out
// depends on ntps_pkg for field widths
`timescale 1ns / 1ps

interface ntps_atom_if;
  logic                                  valid;
  logic                                  ready;
  logic [ntps_pkg::IDX_W-1:0]            atom_index;
  logic                                  is_hydrogen;
  logic signed [ntps_pkg::COORD_W-1:0]   pos_x;
  logic signed [ntps_pkg::COORD_W-1:0]   pos_y;
  logic signed [ntps_pkg::COORD_W-1:0]   pos_z;
  logic                                  last_atom;

  modport source (output valid, atom_index, is_hydrogen, pos_x, pos_y, pos_z, last_atom,
                  input ready);
  modport sink (input valid, atom_index, is_hydrogen, pos_x, pos_y, pos_z, last_atom,
                output ready);
endinterface

interface ntps_result_if;
  logic                       valid;
  logic                       ready;
  logic [ntps_pkg::IDX_W-1:0] first_index;
  logic [ntps_pkg::IDX_W-1:0] second_index;
  logic [ntps_pkg::IDX_W-1:0] third_index;
  logic [1:0]                 found_count;

  modport source (output valid, first_index, second_index, third_index, found_count,
                  input ready);
  modport sink (input valid, first_index, second_index, third_index, found_count,
                output ready);
endinterface

### hw/rtl/ntps_front.sv
// front end: accepts atoms and computes the saturated minimum-image squared distance
// six-stage free-running pipeline, admission by queue credit; depends on ntps_pkg, ntps_intf
`timescale 1ns / 1ps

module ntps_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ntps_atom_if.sink                   atom_i,
  input  ntps_pkg::cfg_t              cfg_i,
  input  logic [ntps_pkg::QCNT_W-1:0] q_level_i,
  output logic                        push_o,
  output ntps_pkg::dist_item_t        push_item_o
);

  localparam int unsigned SUM_W = ntps_pkg::QCNT_W + 1;

  logic                        accept;
  logic [ntps_pkg::INFL_W-1:0] inflight;
  logic [SUM_W-1:0]            credit_used;

  logic [ntps_pkg::PIPE_DEPTH-1:0] v_q;
  ntps_pkg::meta_t                 meta_q [ntps_pkg::PIPE_DEPTH];
  ntps_pkg::meta_t                 meta_d;

  logic signed [31:0] pos [3];
  logic signed [31:0] ctr [3];
  logic signed [33:0] box34;
  logic signed [34:0] box35;
  logic signed [35:0] box36;

  logic signed [33:0] p2      [3];
  logic signed [33:0] s1_p_d  [3];
  logic signed [33:0] s1_p_q  [3];
  logic signed [34:0] s2_d_d  [3];
  logic signed [34:0] s2_d_q  [3];
  logic signed [35:0] d2      [3];
  logic signed [34:0] s3_d_d  [3];
  logic signed [34:0] s3_d_q  [3];
  logic        [34:0] mag     [3];
  logic        [31:0] s4_m_d  [3];
  logic        [31:0] s4_m_q  [3];
  logic               s4_big_d [3];
  logic               s4_big_q [3];
  logic        [63:0] s5_sq_d [3];
  logic        [63:0] s5_sq_q [3];
  logic        [65:0] sum;
  logic        [63:0] s6_dist_d;
  logic        [63:0] s6_dist_q;

  // room in the queue for everything already in flight plus this one
  assign inflight    = ntps_pkg::INFL_W'($countones(v_q));
  assign credit_used = SUM_W'(q_level_i) + SUM_W'(inflight);
  assign atom_i.ready = (credit_used < SUM_W'(ntps_pkg::QDEPTH));
  assign accept      = atom_i.valid && atom_i.ready;

  assign pos[0] = atom_i.pos_x;
  assign pos[1] = atom_i.pos_y;
  assign pos[2] = atom_i.pos_z;
  assign ctr[0] = cfg_i.center_x;
  assign ctr[1] = cfg_i.center_y;
  assign ctr[2] = cfg_i.center_z;
  assign box34  = $signed({10'b0, cfg_i.box_edge});
  assign box35  = $signed({11'b0, cfg_i.box_edge});
  assign box36  = $signed({12'b0, cfg_i.box_edge});

  always_comb begin
    meta_d.consider = atom_i.is_hydrogen &&
                      (32'(atom_i.atom_index) < 32'(ntps_pkg::MAX_ATOMS));
    meta_d.idx      = atom_i.atom_index;
    meta_d.last     = atom_i.last_atom;
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // wrap coordinate into [-box/2, box/2)
      p2[a] = 34'(pos[a]) <<< 1;
      if (p2[a] < -box34) begin
        s1_p_d[a] = 34'(pos[a]) + box34;
      end else if (p2[a] >= box34) begin
        s1_p_d[a] = 34'(pos[a]) - box34;
      end else begin
        s1_p_d[a] = 34'(pos[a]);
      end

      s2_d_d[a] = 35'(s1_p_q[a]) - 35'(ctr[a]);

      // wrap difference into (-box/2, box/2]
      d2[a] = 36'(s2_d_q[a]) <<< 1;
      if (d2[a] > box36) begin
        s3_d_d[a] = s2_d_q[a] - box35;
      end else if (d2[a] <= -box36) begin
        s3_d_d[a] = s2_d_q[a] + box35;
      end else begin
        s3_d_d[a] = s2_d_q[a];
      end

      mag[a]      = s3_d_q[a][34] ? 35'(-s3_d_q[a]) : 35'(s3_d_q[a]);
      s4_m_d[a]   = mag[a][31:0];
      s4_big_d[a] = |mag[a][34:32];

      s5_sq_d[a] = s4_big_q[a] ? {64{1'b1}} : (64'(s4_m_q[a]) * 64'(s4_m_q[a]));
    end
    sum       = 66'(s5_sq_q[0]) + 66'(s5_sq_q[1]) + 66'(s5_sq_q[2]);
    s6_dist_d = (|sum[65:64]) ? {64{1'b1}} : sum[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[ntps_pkg::PIPE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= meta_d;
    for (int k = 1; k < ntps_pkg::PIPE_DEPTH; k++) begin
      meta_q[k] <= meta_q[k-1];
    end
    for (int a = 0; a < 3; a++) begin
      s1_p_q[a]   <= s1_p_d[a];
      s2_d_q[a]   <= s2_d_d[a];
      s3_d_q[a]   <= s3_d_d[a];
      s4_m_q[a]   <= s4_m_d[a];
      s4_big_q[a] <= s4_big_d[a];
      s5_sq_q[a]  <= s5_sq_d[a];
    end
    s6_dist_q <= s6_dist_d;
  end

  assign push_o           = v_q[ntps_pkg::PIPE_DEPTH-1];
  assign push_item_o.meta = meta_q[ntps_pkg::PIPE_DEPTH-1];
  assign push_item_o.dsq  = s6_dist_q;

endmodule

### hw/rtl/ntps_queue.sv
// short queue between the distance front end and the slot back end
// register-based ring buffer with a fill level; depends on ntps_pkg
`timescale 1ns / 1ps

module ntps_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  ntps_pkg::dist_item_t        push_item_i,
  output logic                        pop_valid_o,
  input  logic                        pop_ready_i,
  output ntps_pkg::dist_item_t        pop_item_o,
  output logic [ntps_pkg::QCNT_W-1:0] level_o
);

  ntps_pkg::dist_item_t        mem_q [ntps_pkg::QDEPTH];
  logic [ntps_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [ntps_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ntps_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                        pop;

  assign pop_valid_o = (cnt_q != '0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_item_o  = mem_q[rd_ptr_q];
  assign level_o     = cnt_q;

  // the front end only pushes when credit guarantees a free entry
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + ntps_pkg::QCNT_W'(push_i) - ntps_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hw/rtl/ntps_back.sv
// back end: three sorted nearest slots and result output register; depends on ntps_pkg, ntps_intf
// one insertion per cycle, but a last atom waits while a result is unread, then emits and clears
`timescale 1ns / 1ps

module ntps_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  ntps_pkg::dist_item_t item_i,
  output logic                 item_ready_o,
  ntps_result_if.source        result_o
);

  logic [ntps_pkg::DIST_W-1:0] dist_q [3];
  logic [ntps_pkg::DIST_W-1:0] dist_d [3];
  logic [ntps_pkg::IDX_W-1:0]  idx_q  [3];
  logic [ntps_pkg::IDX_W-1:0]  idx_d  [3];
  logic [2:0]                  vld_q, vld_d;

  logic                        take;
  logic                        emit;
  logic [ntps_pkg::DIST_W-1:0] d;
  logic [ntps_pkg::IDX_W-1:0]  id;

  logic                        out_valid_q, out_valid_d;
  logic [ntps_pkg::IDX_W-1:0]  first_q, second_q, third_q;
  logic [ntps_pkg::IDX_W-1:0]  first_d, second_d, third_d;
  logic [1:0]                  count_q, count_d;

  // a last atom needs the output register free or draining
  assign item_ready_o = !item_i.meta.last || !out_valid_q || result_o.ready;
  assign take         = item_valid_i && item_ready_o;
  assign emit         = take && item_i.meta.last;
  assign d            = item_i.dsq;
  assign id           = item_i.meta.idx;

  // insertion, equal distances are dropped
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dist_d[k] = dist_q[k];
      idx_d[k]  = idx_q[k];
    end
    vld_d = vld_q;
    if (item_i.meta.consider) begin
      priority if (d < dist_q[2] && d > dist_q[1]) begin
        dist_d[2] = d;
        idx_d[2]  = id;
        vld_d[2]  = 1'b1;
      end else if (d < dist_q[1] && d > dist_q[0]) begin
        dist_d[2] = dist_q[1];
        idx_d[2]  = idx_q[1];
        vld_d[2]  = vld_q[1];
        dist_d[1] = d;
        idx_d[1]  = id;
        vld_d[1]  = 1'b1;
      end else if (d < dist_q[0]) begin
        dist_d[2] = dist_q[1];
        idx_d[2]  = idx_q[1];
        vld_d[2]  = vld_q[1];
        dist_d[1] = dist_q[0];
        idx_d[1]  = idx_q[0];
        vld_d[1]  = vld_q[0];
        dist_d[0] = d;
        idx_d[0]  = id;
        vld_d[0]  = 1'b1;
      end else begin
        vld_d = vld_q;
      end
    end
  end

  // pack valid slots in slot order, unused fields read zero
  always_comb begin
    first_d  = '0;
    second_d = '0;
    third_d  = '0;
    count_d  = 2'd0;
    unique case (vld_d)
      3'b000: count_d = 2'd0;
      3'b001: begin
        first_d = idx_d[0];
        count_d = 2'd1;
      end
      3'b010: begin
        first_d = idx_d[1];
        count_d = 2'd1;
      end
      3'b100: begin
        first_d = idx_d[2];
        count_d = 2'd1;
      end
      3'b011: begin
        first_d  = idx_d[0];
        second_d = idx_d[1];
        count_d  = 2'd2;
      end
      3'b101: begin
        first_d  = idx_d[0];
        second_d = idx_d[2];
        count_d  = 2'd2;
      end
      3'b110: begin
        first_d  = idx_d[1];
        second_d = idx_d[2];
        count_d  = 2'd2;
      end
      3'b111: begin
        first_d  = idx_d[0];
        second_d = idx_d[1];
        third_d  = idx_d[2];
        count_d  = 2'd3;
      end
      default: count_d = 2'd0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q[0]   <= ntps_pkg::SENT0;
      dist_q[1]   <= ntps_pkg::SENT1;
      dist_q[2]   <= ntps_pkg::SENT2;
      idx_q[0]    <= '0;
      idx_q[1]    <= '0;
      idx_q[2]    <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (emit) begin
        dist_q[0] <= ntps_pkg::SENT0;
        dist_q[1] <= ntps_pkg::SENT1;
        dist_q[2] <= ntps_pkg::SENT2;
        idx_q[0]  <= '0;
        idx_q[1]  <= '0;
        idx_q[2]  <= '0;
        vld_q     <= '0;
      end else if (take) begin
        dist_q <= dist_d;
        idx_q  <= idx_d;
        vld_q  <= vld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      first_q  <= first_d;
      second_q <= second_d;
      third_q  <= third_d;
      count_q  <= count_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.first_index  = first_q;
  assign result_o.second_index = second_q;
  assign result_o.third_index  = third_q;
  assign result_o.found_count  = count_q;

endmodule

### hw/rtl/nearest_three_periodic_select_core.sv
// top level of the nearest-three periodic select block
// holds the configuration registers and joins front end, queue and back end;
// depends on ntps_pkg, ntps_intf, ntps_front, ntps_queue, ntps_back
//
// usage:
//   atom_i carries one atom per request: index, hydrogen flag, Q16.16 x/y/z and a
//   last-of-frame mark. result_o carries one request per frame, on its last atom:
//   the indexes of the up to three nearest hydrogens and how many were found.
//   the config port writes box size (index 0) and center x/y/z (1..3); write only
//   while no frame is in progress and the block has drained.
// path: a last atom's result passes the 6 distance stages, the first loaded at
//   the edge that accepts it, then the queue and the slot update into the output
//   register, and it can wait in the queue while an earlier result is unread.
// throughput: one atom per cycle while atom_i.ready is high, set by slot insertion.
//   atom_i.ready drops when the atoms in the 8-entry queue plus those in the
//   distance pipeline reach its room, so a stalled receiver back-pressures input
//   only when a last atom waits at the queue head and the queue fills behind it.
// reset: box size 15.8122 angstroms, center at origin, slots at the 16/17/18
//   angstrom sentinels, queue empty, no result pending.
`timescale 1ns / 1ps

module nearest_three_periodic_select_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ntps_atom_if.sink                       atom_i,
  ntps_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [ntps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ntps_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  ntps_pkg::cfg_t              cfg_q;
  logic                        push;
  ntps_pkg::dist_item_t        push_item;
  logic                        pop_valid;
  logic                        pop_ready;
  ntps_pkg::dist_item_t        pop_item;
  logic [ntps_pkg::QCNT_W-1:0] q_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_edge <= ntps_pkg::BOX_RESET;
      cfg_q.center_x <= '0;
      cfg_q.center_y <= '0;
      cfg_q.center_z <= '0;
    end else if (cfg_we_i) begin
      unique case (ntps_pkg::cfg_reg_e'(cfg_idx_i))
        ntps_pkg::REG_BOX_EDGE: cfg_q.box_edge <= cfg_wdata_i[ntps_pkg::BOX_W-1:0];
        ntps_pkg::REG_CENTER_X: cfg_q.center_x <= $signed(cfg_wdata_i);
        ntps_pkg::REG_CENTER_Y: cfg_q.center_y <= $signed(cfg_wdata_i);
        ntps_pkg::REG_CENTER_Z: cfg_q.center_z <= $signed(cfg_wdata_i);
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  ntps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .atom_i      (atom_i),
    .cfg_i       (cfg_q),
    .q_level_i   (q_level),
    .push_o      (push),
    .push_item_o (push_item)
  );

  ntps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item),
    .level_o     (q_level)
  );

  ntps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .result_o     (result_o)
  );

endmodule
